// File: hdl/dbd_pkg.sv
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int LOGIT_W = 11;
  localparam int FRAC_W = 16;
  localparam int DIM_W = 13;
  localparam int PIX_BITS = 12;
  localparam int SCORE_W = 16;

  localparam int SIG_ENTRIES = 1024;
  localparam int SIG_HALF = SIG_ENTRIES / 2;
  localparam int SIG_AW = $clog2(SIG_ENTRIES);
  localparam int OFS_W = ((SIG_AW > LOGIT_W) ? SIG_AW : LOGIT_W) + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_KEEP_THRESH = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [SCORE_W-1:0] RST_KEEP_THRESH = 16'd32768;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH = 13'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = {1'b1, {(LOGIT_W-1){1'b0}}};

  typedef struct packed {
    logic [SCORE_W-1:0] keep_thresh;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
  } cfg_t;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] best_logit;
    logic [FRAC_W-1:0]         center_x;
    logic [FRAC_W-1:0]         center_y;
    logic [FRAC_W-1:0]         box_width;
    logic [FRAC_W-1:0]         box_height;
    logic                      last_query;
  } query_t;

  typedef logic [SCORE_W-1:0] sig_rom_t [SIG_ENTRIES];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [SCORE_W-1:0] sat16(input logic [63:0] v);
    return (v > 64'd65535) ? {SCORE_W{1'b1}} : v[SCORE_W-1:0];
  endfunction

  // entry i holds sigmoid((i - SIG_HALF) / 64), exp via fixed-point recurrence
  function automatic sig_rom_t sig_rom_build();
    sig_rom_t rom;
    logic [63:0] e;
    logic [63:0] d;
    logic [95:0] p;
    e = 64'h1_0000_0000;
    for (int m = 0; m <= SIG_HALF; m++) begin
      d = 64'h1_0000_0000 + e;
      if (m < SIG_HALF) begin
        rom[SIG_HALF + m] = sat16(udiv64((64'd1 << 48) + (d >> 1), d));
      end
      rom[SIG_HALF - m] = sat16(udiv64((e << 16) + (d >> 1), d));
      p = {32'd0, e} * 96'd4228380000 + (96'd1 << 31);
      e = p[95:32];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = sig_rom_build();

endpackage

// File: hdl/dbd_front.sv
`timescale 1ns / 1ps

module dbd_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [dbd_pkg::LOGIT_W-1:0]    in_logit,
  input  logic [dbd_pkg::FRAC_W-1:0]            in_center_x,
  input  logic [dbd_pkg::FRAC_W-1:0]            in_center_y,
  input  logic [dbd_pkg::FRAC_W-1:0]            in_box_width,
  input  logic [dbd_pkg::FRAC_W-1:0]            in_box_height,
  input  logic                                  in_last_class,
  input  logic                                  in_last_query,
  input  logic                                  q_full,
  output logic                                  q_push,
  output dbd_pkg::query_t                       q_wdata
);

  logic signed [dbd_pkg::LOGIT_W-1:0] best_r;
  logic signed [dbd_pkg::LOGIT_W-1:0] best_nxt;
  logic signed [dbd_pkg::LOGIT_W-1:0] run_max;
  logic                               accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign run_max  = (in_logit > best_r) ? in_logit : best_r;
  assign best_nxt = in_last_class ? dbd_pkg::LOGIT_MIN : run_max;

  assign q_push              = accept & in_last_class;
  assign q_wdata.best_logit  = run_max;
  assign q_wdata.center_x    = in_center_x;
  assign q_wdata.center_y    = in_center_y;
  assign q_wdata.box_width   = in_box_width;
  assign q_wdata.box_height  = in_box_height;
  assign q_wdata.last_query  = in_last_query;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= dbd_pkg::LOGIT_MIN;
    end else if (accept) begin
      best_r <= best_nxt;
    end
  end

endmodule

// File: hdl/dbd_queue.sv
`timescale 1ns / 1ps

module dbd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dbd_pkg::query_t wdata,
  input  logic            pop,
  output dbd_pkg::query_t rdata,
  output logic            full,
  output logic            not_empty
);

  dbd_pkg::query_t                 mem_r [dbd_pkg::QUEUE_DEPTH];
  logic [dbd_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [dbd_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [dbd_pkg::QUEUE_AW:0]      count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count_r == (dbd_pkg::QUEUE_AW+1)'(dbd_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  function automatic logic [dbd_pkg::QUEUE_AW-1:0] ptr_inc(
    input logic [dbd_pkg::QUEUE_AW-1:0] p
  );
    return (p == (dbd_pkg::QUEUE_AW)'(dbd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/dbd_back.sv
`timescale 1ns / 1ps

module dbd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dbd_pkg::cfg_t                      cfg,
  input  logic                               q_not_empty,
  input  dbd_pkg::query_t                    q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_box_valid,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_left,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_top,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_right,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_bottom,
  output logic [dbd_pkg::SCORE_W-1:0]        out_score,
  output logic [dbd_pkg::SCORE_W-1:0]        out_max_score,
  output logic                               out_frame_done
);

  localparam int POS_W  = dbd_pkg::FRAC_W + 3;
  localparam int SDIM_W = dbd_pkg::PIX_BITS + 2;
  localparam int PROD_W = POS_W + SDIM_W;
  localparam int RND_SH = dbd_pkg::FRAC_W + 1;
  localparam int PX_W   = PROD_W + 1 - RND_SH;
  localparam logic [dbd_pkg::DIM_W-1:0] DIM_MAX = (dbd_pkg::DIM_W)'(1 << dbd_pkg::PIX_BITS);

  logic                                 adv;
  logic [dbd_pkg::PIX_BITS:0]           w_sat;
  logic [dbd_pkg::PIX_BITS:0]           h_sat;
  logic signed [dbd_pkg::OFS_W-1:0]     ofs;
  logic [dbd_pkg::SIG_AW-1:0]           rom_idx;
  logic signed [POS_W-1:0]              pos_l;
  logic signed [POS_W-1:0]              pos_t;
  logic signed [POS_W-1:0]              pos_r;
  logic signed [POS_W-1:0]              pos_b;

  logic                                 s1_valid_r;
  logic [dbd_pkg::SCORE_W-1:0]          s1_score_r;
  logic signed [PROD_W-1:0]             s1_prod_r [4];
  logic                                 s1_lq_r;

  logic                                 box_ok;
  logic [dbd_pkg::SCORE_W-1:0]          max_r;
  logic [dbd_pkg::SCORE_W-1:0]          max_nxt;

  logic                                 out_valid_r;
  logic                                 box_valid_r;
  logic [dbd_pkg::PIX_BITS-1:0]         left_r;
  logic [dbd_pkg::PIX_BITS-1:0]         top_r;
  logic [dbd_pkg::PIX_BITS-1:0]         right_r;
  logic [dbd_pkg::PIX_BITS-1:0]         bottom_r;
  logic [dbd_pkg::SCORE_W-1:0]          score_r;
  logic [dbd_pkg::SCORE_W-1:0]          max_out_r;
  logic                                 done_r;

  function automatic logic [dbd_pkg::PIX_BITS:0] sat_dim(input logic [dbd_pkg::DIM_W-1:0] v);
    logic [dbd_pkg::DIM_W-1:0] s;
    if (v == '0) begin
      s = (dbd_pkg::DIM_W)'(1);
    end else if (v > DIM_MAX) begin
      s = DIM_MAX;
    end else begin
      s = v;
    end
    return s[dbd_pkg::PIX_BITS:0];
  endfunction

  function automatic logic [dbd_pkg::PIX_BITS-1:0] corner(
    input logic signed [PROD_W-1:0] prod,
    input logic [dbd_pkg::PIX_BITS:0] dim
  );
    logic signed [PROD_W:0] v;
    logic [PX_W-1:0]        px;
    logic [PX_W-1:0]        lim;
    v   = $signed({prod[PROD_W-1], prod}) + $signed((PROD_W+1)'(1 << dbd_pkg::FRAC_W));
    px  = v[PROD_W:RND_SH];
    lim = (PX_W)'(dim) - 1'b1;
    if (v < 0) begin
      return '0;
    end else if (px > lim) begin
      return lim[dbd_pkg::PIX_BITS-1:0];
    end else begin
      return px[dbd_pkg::PIX_BITS-1:0];
    end
  endfunction

  assign adv   = ~out_valid_r | ~out_stall;
  assign q_pop = adv & q_not_empty;
  assign w_sat = sat_dim(cfg.frame_width);
  assign h_sat = sat_dim(cfg.frame_height);

  // clamp best logit into the rom range
  always_comb begin
    ofs = $signed((dbd_pkg::OFS_W)'(q_rdata.best_logit))
        + $signed((dbd_pkg::OFS_W)'(dbd_pkg::SIG_HALF));
    if (ofs < 0) begin
      rom_idx = '0;
    end else if (ofs > $signed((dbd_pkg::OFS_W)'(dbd_pkg::SIG_ENTRIES - 1))) begin
      rom_idx = (dbd_pkg::SIG_AW)'(dbd_pkg::SIG_ENTRIES - 1);
    end else begin
      rom_idx = ofs[dbd_pkg::SIG_AW-1:0];
    end
  end

  // box edges in signed Q1.17
  assign pos_l = $signed({2'b00, q_rdata.center_x, 1'b0}) - $signed({3'b000, q_rdata.box_width});
  assign pos_r = $signed({2'b00, q_rdata.center_x, 1'b0}) + $signed({3'b000, q_rdata.box_width});
  assign pos_t = $signed({2'b00, q_rdata.center_y, 1'b0}) - $signed({3'b000, q_rdata.box_height});
  assign pos_b = $signed({2'b00, q_rdata.center_y, 1'b0}) + $signed({3'b000, q_rdata.box_height});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_score_r   <= dbd_pkg::SIG_ROM[rom_idx];
      s1_prod_r[0] <= pos_l * $signed({1'b0, w_sat});
      s1_prod_r[1] <= pos_t * $signed({1'b0, h_sat});
      s1_prod_r[2] <= pos_r * $signed({1'b0, w_sat});
      s1_prod_r[3] <= pos_b * $signed({1'b0, h_sat});
      s1_lq_r      <= q_rdata.last_query;
    end
  end

  assign box_ok  = (s1_score_r >= cfg.keep_thresh);
  assign max_nxt = (box_ok && (s1_score_r > max_r)) ? s1_score_r : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      max_r       <= '0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        max_r <= s1_lq_r ? '0 : max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      box_valid_r <= box_ok;
      left_r      <= box_ok ? corner(s1_prod_r[0], w_sat) : '0;
      top_r       <= box_ok ? corner(s1_prod_r[1], h_sat) : '0;
      right_r     <= box_ok ? corner(s1_prod_r[2], w_sat) : '0;
      bottom_r    <= box_ok ? corner(s1_prod_r[3], h_sat) : '0;
      score_r     <= s1_score_r;
      max_out_r   <= max_nxt;
      done_r      <= s1_lq_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_box_valid  = box_valid_r;
  assign out_left       = left_r;
  assign out_top        = top_r;
  assign out_right      = right_r;
  assign out_bottom     = bottom_r;
  assign out_score      = score_r;
  assign out_max_score  = max_out_r;
  assign out_frame_done = done_r;

endmodule

// File: hdl/detection_box_decode_unit.sv
`timescale 1ns / 1ps

// Detection box decoder. Takes one class logit per beat, one beat per clock while
// in_stall is low, and keeps the running maximum for the current query. The beat flagged
// last_class pushes the query into a four-entry queue; the back end pops one query per
// clock while the output is not stalled, looks its best logit up in a 1024-entry
// registered sigmoid ROM while the four corner multiplies run, and then thresholds, rounds
// and clamps the corners into the output register. A result passes through the queue, the
// stage-1 register and the output register; input stalls only when the queue is full
// because the result side is stalled. Frame sizes saturate to 1..4096 where they are used.
// No clearing pass is needed after reset.

module detection_box_decode_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [dbd_pkg::LOGIT_W-1:0] in_logit,
  input  logic [dbd_pkg::FRAC_W-1:0]         in_center_x,
  input  logic [dbd_pkg::FRAC_W-1:0]         in_center_y,
  input  logic [dbd_pkg::FRAC_W-1:0]         in_box_width,
  input  logic [dbd_pkg::FRAC_W-1:0]         in_box_height,
  input  logic                               in_last_class,
  input  logic                               in_last_query,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_box_valid,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_left,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_top,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_right,
  output logic [dbd_pkg::PIX_BITS-1:0]       out_bottom,
  output logic [dbd_pkg::SCORE_W-1:0]        out_score,
  output logic [dbd_pkg::SCORE_W-1:0]        out_max_score,
  output logic                               out_frame_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dbd_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [dbd_pkg::CFG_DW-1:0]         cfg_data
);

  dbd_pkg::cfg_t   cfg_r;
  dbd_pkg::query_t q_wdata;
  dbd_pkg::query_t q_rdata;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep_thresh  <= dbd_pkg::RST_KEEP_THRESH;
      cfg_r.frame_width  <= dbd_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= dbd_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbd_pkg::CFG_KEEP_THRESH: begin
          cfg_r.keep_thresh <= cfg_data[dbd_pkg::SCORE_W-1:0];
        end
        dbd_pkg::CFG_FRAME_WIDTH: begin
          cfg_r.frame_width <= cfg_data[dbd_pkg::DIM_W-1:0];
        end
        dbd_pkg::CFG_FRAME_HEIGHT: begin
          cfg_r.frame_height <= cfg_data[dbd_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  dbd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_logit      (in_logit),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_last_class (in_last_class),
    .in_last_query (in_last_query),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  dbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  dbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_not_empty    (q_not_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_box_valid  (out_box_valid),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_score      (out_score),
    .out_max_score  (out_max_score),
    .out_frame_done (out_frame_done)
  );

endmodule

// File: hdl/dbd_checker.sv
`timescale 1ns / 1ps

module dbd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_box_valid,
  input logic [dbd_pkg::PIX_BITS-1:0]       out_left,
  input logic [dbd_pkg::PIX_BITS-1:0]       out_top,
  input logic [dbd_pkg::PIX_BITS-1:0]       out_right,
  input logic [dbd_pkg::PIX_BITS-1:0]       out_bottom,
  input logic [dbd_pkg::SCORE_W-1:0]        out_score,
  input logic [dbd_pkg::SCORE_W-1:0]        out_max_score,
  input logic                               out_frame_done
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score) && $stable(out_left)
      && $stable(out_right) && $stable(out_max_score) && $stable(out_frame_done))
    else $error("stalled result beat changed");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_box_valid |-> out_left == '0 && out_top == '0
      && out_right == '0 && out_bottom == '0)
    else $error("dropped box with nonzero corners");

  a_kept_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_box_valid |-> out_max_score >= out_score
      && out_left <= out_right && out_top <= out_bottom)
    else $error("kept box inconsistent");

endmodule

bind detection_box_decode_unit dbd_checker u_dbd_checker (.*);
